// ----- design/lfr_pkg.sv -----
// Package for the linear fade ramp generator.
// Holds request codes, fixed field widths and the state types.
// No dependencies.
package lfr_pkg;

  // Fixed field widths
  localparam int unsigned REQ_W = 3;
  localparam int unsigned ID_W  = 8;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_START  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PAUSE  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_RESUME = 3'd3;
  localparam logic [REQ_W-1:0] REQ_STOP   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_ADD    = 3'd5;

  // Top-level sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_SEND
  } lfr_state_t;

  // Serial multiply/divide phases
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MUL,
    PH_DIV
  } lfr_phase_t;

endpackage

// ----- design/lfr_ramp_unit.sv -----
// Bit-serial ramp step unit: q = floor(elapsed * diff / length).
// One shift-add multiply bit per cycle, then one restoring divide bit per cycle.
// Depends on lfr_pkg.
module lfr_ramp_unit
  import lfr_pkg::*;
#(
  parameter int unsigned LEVEL_WIDTH = 16,
  parameter int unsigned TIME_WIDTH  = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [TIME_WIDTH-1:0]  elapsed,
  input  logic [LEVEL_WIDTH-1:0] diff,
  input  logic [TIME_WIDTH-1:0]  length,
  output logic                   done,
  output logic [LEVEL_WIDTH-1:0] quot
);

  localparam int unsigned PW    = LEVEL_WIDTH + TIME_WIDTH;
  localparam int unsigned MAXW  = (TIME_WIDTH > LEVEL_WIDTH) ? TIME_WIDTH : LEVEL_WIDTH;
  localparam int unsigned CNT_W = $clog2(MAXW);

  lfr_phase_t             ph_r, ph_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   done_r, done_nxt;
  logic [PW-1:0]          prod_r, prod_nxt;
  logic [LEVEL_WIDTH-1:0] mcand_r, mcand_nxt;
  logic [TIME_WIDTH-1:0]  len_r, len_nxt;

  // datapath step terms
  logic [LEVEL_WIDTH:0]   mul_sum;
  logic [TIME_WIDTH:0]    div_trial;
  logic [TIME_WIDTH-1:0]  div_sub;
  logic                   div_ge;
  logic [TIME_WIDTH-1:0]  div_rem;

  // multiply step: add multiplicand into the upper half, shift right
  assign mul_sum = {1'b0, prod_r[PW-1:TIME_WIDTH]}
                 + (prod_r[0] ? {1'b0, mcand_r} : '0);

  // divide step: shift one product bit into the remainder, trial subtract
  // (the difference is below length whenever it is kept, so TIME_WIDTH bits hold it)
  assign div_trial = {prod_r[PW-1:LEVEL_WIDTH], prod_r[LEVEL_WIDTH-1]};
  assign div_sub   = div_trial[TIME_WIDTH-1:0] - len_r;
  assign div_ge    = (div_trial >= {1'b0, len_r});
  assign div_rem   = div_ge ? div_sub : div_trial[TIME_WIDTH-1:0];

  always_comb begin
    ph_nxt    = ph_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    prod_nxt  = prod_r;
    mcand_nxt = mcand_r;
    len_nxt   = len_r;
    unique case (ph_r)
      PH_IDLE: begin
        if (start) begin
          prod_nxt  = {{LEVEL_WIDTH{1'b0}}, elapsed};
          mcand_nxt = diff;
          len_nxt   = length;
          cnt_nxt   = CNT_W'(TIME_WIDTH - 1);
          ph_nxt    = PH_MUL;
        end
      end
      PH_MUL: begin
        prod_nxt = {mul_sum, prod_r[TIME_WIDTH-1:1]};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          cnt_nxt = CNT_W'(LEVEL_WIDTH - 1);
          ph_nxt  = PH_DIV;
        end
      end
      PH_DIV: begin
        prod_nxt = {div_rem, prod_r[LEVEL_WIDTH-2:0], div_ge};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          done_nxt = 1'b1;
          ph_nxt   = PH_IDLE;
        end
      end
      default: ph_nxt = PH_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // operand and shift registers
  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    mcand_r <= mcand_nxt;
    len_r   <= len_nxt;
  end

  assign done = done_r;
  assign quot = prod_r[LEVEL_WIDTH-1:0];

endmodule

// ----- design/linear_fade_ramp_generator_top.sv -----
// Top level of the linear fade ramp generator.
// Holds the fade state, the request sequencer and the output register.
// Depends on lfr_pkg and lfr_ramp_unit.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request per beat: tick,
//   start fade, pause, resume, stop or add time, with the master enable,
//   target level and a duration. Every request yields exactly one result
//   beat on the output channel (out_valid/out_ready) with the level, the
//   running flag, the end flag with its fade id, and the tick counters.
//   cfg_we/cfg_wdata write the fade id; write it only while idle.
//   A request that does not move the ramp has its result in the output
//   register in the cycle after acceptance. A tick that moves the ramp
//   runs the serial multiply/divide unit, a multiply phase then a divide
//   phase; the sequencer waits for it in ST_CALC, then loads the result
//   from ST_SEND once the output register is free.
//   One request is in flight at a time; the next beat is taken once its
//   result has been loaded and the output register is free or being read.
//   A stalled receiver holds the output register and with it the input.
//   Reset (rst_n low, synchronous) clears the level, all fade state and the
//   fade id to zero, with no result pending.
module linear_fade_ramp_generator_top
  import lfr_pkg::*;
#(
  parameter int unsigned LEVEL_WIDTH = 16,
  parameter int unsigned TIME_WIDTH  = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration
  input  logic                   cfg_we,
  input  logic [ID_W-1:0]        cfg_wdata,
  // request channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [REQ_W-1:0]       in_req_type,
  input  logic                   in_master_active,
  input  logic [LEVEL_WIDTH-1:0] in_target_level,
  input  logic [TIME_WIDTH-1:0]  in_duration_ticks,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [LEVEL_WIDTH-1:0] out_level,
  output logic                   out_fade_running,
  output logic                   out_fade_end,
  output logic [ID_W-1:0]        out_end_id,
  output logic [TIME_WIDTH-1:0]  out_ticks_left,
  output logic [TIME_WIDTH-1:0]  out_ticks_elapsed
);

  localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

  lfr_state_t             state_r, state_nxt;
  logic [ID_W-1:0]        fade_id_r;
  logic                   running_r, running_nxt;
  logic                   held_r, held_nxt;
  logic [LEVEL_WIDTH-1:0] start_lvl_r, start_lvl_nxt;
  logic [LEVEL_WIDTH-1:0] end_lvl_r, end_lvl_nxt;
  logic [LEVEL_WIDTH-1:0] cur_lvl_r, cur_lvl_nxt;
  logic [TIME_WIDTH-1:0]  elapsed_r, elapsed_nxt;
  logic [TIME_WIDTH-1:0]  length_r, length_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [LEVEL_WIDTH-1:0] out_level_r;
  logic                   out_running_r;
  logic                   out_end_r;
  logic [ID_W-1:0]        out_id_r;
  logic [TIME_WIDTH-1:0]  out_left_r;
  logic [TIME_WIDTH-1:0]  out_elapsed_r;

  logic                   out_free;
  logic                   in_fire;
  logic                   load_out;
  logic                   ended;
  logic                   ramp_start;
  logic                   ramp_done;
  logic [LEVEL_WIDTH-1:0] ramp_quot;
  logic                   rising;
  logic [LEVEL_WIDTH-1:0] lvl_diff;
  logic [LEVEL_WIDTH-1:0] ramp_lvl;
  logic [TIME_WIDTH:0]    el_inc;
  logic [TIME_WIDTH-1:0]  el_sat;
  logic [TIME_WIDTH:0]    len_add;
  logic [TIME_WIDTH-1:0]  len_sat;
  logic                   tick_live;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;

  // ramp direction and span
  assign rising   = (end_lvl_r >= start_lvl_r);
  assign lvl_diff = rising ? (end_lvl_r - start_lvl_r) : (start_lvl_r - end_lvl_r);
  assign ramp_lvl = rising ? (start_lvl_r + ramp_quot) : (start_lvl_r - ramp_quot);

  // saturating time adds
  assign el_inc  = {1'b0, elapsed_r} + 1'b1;
  assign el_sat  = el_inc[TIME_WIDTH] ? TIME_MAX : el_inc[TIME_WIDTH-1:0];
  assign len_add = {1'b0, length_r} + {1'b0, in_duration_ticks};
  assign len_sat = len_add[TIME_WIDTH] ? TIME_MAX : len_add[TIME_WIDTH-1:0];

  assign tick_live = running_r && !held_r && in_master_active;

  lfr_ramp_unit #(
    .LEVEL_WIDTH (LEVEL_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_ramp (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (ramp_start),
    .elapsed (el_sat),
    .diff    (lvl_diff),
    .length  (length_r),
    .done    (ramp_done),
    .quot    (ramp_quot)
  );

  // request sequencer and state update
  always_comb begin
    state_nxt     = state_r;
    running_nxt   = running_r;
    held_nxt      = held_r;
    start_lvl_nxt = start_lvl_r;
    end_lvl_nxt   = end_lvl_r;
    cur_lvl_nxt   = cur_lvl_r;
    elapsed_nxt   = elapsed_r;
    length_nxt    = length_r;
    load_out      = 1'b0;
    ended         = 1'b0;
    ramp_start    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          load_out = 1'b1;
          unique case (in_req_type)
            REQ_TICK: begin
              if (tick_live) begin
                elapsed_nxt = el_sat;
                if (el_sat > length_r) begin
                  cur_lvl_nxt = end_lvl_r;
                  running_nxt = 1'b0;
                  ended       = 1'b1;
                end else begin
                  load_out   = 1'b0;
                  ramp_start = 1'b1;
                  state_nxt  = ST_CALC;
                end
              end
            end
            REQ_START: begin
              if (in_master_active) begin
                start_lvl_nxt = cur_lvl_r;
                end_lvl_nxt   = in_target_level;
                elapsed_nxt   = '0;
                length_nxt    = in_duration_ticks;
                running_nxt   = 1'b1;
                held_nxt      = 1'b0;
              end
            end
            REQ_PAUSE: begin
              if (running_r) held_nxt = 1'b1;
            end
            REQ_RESUME: begin
              if (running_r && held_r) held_nxt = 1'b0;
            end
            REQ_STOP: running_nxt = 1'b0;
            REQ_ADD:  length_nxt  = len_sat;
            default: ;
          endcase
        end
      end
      ST_CALC: begin
        if (ramp_done) begin
          cur_lvl_nxt = ramp_lvl;
          state_nxt   = ST_SEND;
        end
      end
      ST_SEND: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // control and fade state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fade_id_r   <= '0;
      running_r   <= 1'b0;
      held_r      <= 1'b0;
      start_lvl_r <= '0;
      end_lvl_r   <= '0;
      cur_lvl_r   <= '0;
      elapsed_r   <= '0;
      length_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) fade_id_r <= cfg_wdata;
      running_r   <= running_nxt;
      held_r      <= held_nxt;
      start_lvl_r <= start_lvl_nxt;
      end_lvl_r   <= end_lvl_nxt;
      cur_lvl_r   <= cur_lvl_nxt;
      elapsed_r   <= elapsed_nxt;
      length_r    <= length_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output register, loaded from the updated state
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_level_r   <= cur_lvl_nxt;
      out_running_r <= running_nxt;
      out_end_r     <= ended;
      out_id_r      <= ended ? fade_id_r : '0;
      out_left_r    <= (elapsed_nxt > length_nxt) ? '0 : (length_nxt - elapsed_nxt);
      out_elapsed_r <= elapsed_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_level         = out_level_r;
  assign out_fade_running  = out_running_r;
  assign out_fade_end      = out_end_r;
  assign out_end_id        = out_id_r;
  assign out_ticks_left    = out_left_r;
  assign out_ticks_elapsed = out_elapsed_r;

  // a finished fade reports itself stopped with no ticks left
  a_end_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_end_r |-> !out_running_r && (out_left_r == '0))
    else $error("fade end beat with running flag or ticks left");

  // the serial unit only finishes while the sequencer waits for it
  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    ramp_done |-> (state_r == ST_CALC))
    else $error("ramp unit finished outside of calculation");

  // a result never overwrites one still waiting for the receiver
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_ready))
    else $error("output register overwritten while stalled");

  // a ramp start always leaves the sequencer in calculation
  a_start_calc: assert property (@(posedge clk) disable iff (!rst_n)
    ramp_start |=> (state_r == ST_CALC))
    else $error("ramp started without entering calculation");

endmodule
